### rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCS_DEF = 64;
  localparam int TIME_BITS_DEF = 16;

  localparam int CNT_W = 7;   // process count / completed count
  localparam int IDX_W = 6;   // entry index field
  localparam int PRI_W = 8;   // priority field
  localparam int FLD_W = 16;  // time-valued fields on the channels

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_METRIC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [FLD_W-1:0] arrival_time;
    logic [FLD_W-1:0] burst_time;
    logic [PRI_W-1:0] priority_level;
  } in_item_t;

  typedef struct packed {
    logic             idle;
    logic [IDX_W-1:0] running_index;
    logic             finished;
    logic [FLD_W-1:0] completion_time;
    logic [FLD_W-1:0] turnaround;
    logic [FLD_W-1:0] waiting;
    logic [FLD_W-1:0] response;
    logic             all_done;
    logic [FLD_W-1:0] tick_time;
  } out_item_t;

  typedef struct packed {
    logic start;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

endpackage

### rtl/core/pps_if.sv
// ----------------------------------------------------------------------------
// pps_if
// Valid/ready channels: request input, result output, configuration write.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic               valid;
  logic               ready;
  pps_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  pps_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pps_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::CNT_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/pps_scan.sv
// ----------------------------------------------------------------------------
// pps_scan
// Walks the process table one entry per cycle and keeps the best ready entry.
// ----------------------------------------------------------------------------
module pps_scan #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  pps_pkg::scan_ctl_t                                ctl,
  input  logic [TIME_BITS-1:0]                              t,
  input  logic [pps_pkg::CNT_W-1:0]                         cnt,
  input  logic [4*TIME_BITS+pps_pkg::PRI_W-1:0]             rdata,
  output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] raddr,
  output pps_pkg::scan_sts_t                                sts,
  output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] best_idx,
  output logic [4*TIME_BITS+pps_pkg::PRI_W-1:0]             best_rec
);
  import pps_pkg::*;

  localparam int AW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int TW     = TIME_BITS;
  localparam int RW     = 4 * TW + PRI_W;
  localparam int PRI_LO = TW;
  localparam int REM_LO = TW + PRI_W;
  localparam int ARR_LO = 3 * TW + PRI_W;

  logic             busy_r,     busy_nxt;
  logic [CNT_W-1:0] scan_r,     scan_nxt;
  logic             cmp_v_r,    cmp_v_nxt;
  logic [AW-1:0]    cmp_idx_r,  cmp_idx_nxt;
  logic             found_r,    found_nxt;
  logic [AW-1:0]    best_idx_r, best_idx_nxt;
  logic [RW-1:0]    best_rec_r, best_rec_nxt;

  logic [TW-1:0]    e_arr;
  logic [TW-1:0]    e_rem;
  logic [PRI_W-1:0] e_pri;
  logic [PRI_W-1:0] b_pri;
  logic             e_ready;
  logic             take;
  logic             done;

  assign e_arr = rdata[ARR_LO +: TW];
  assign e_rem = rdata[REM_LO +: TW];
  assign e_pri = rdata[PRI_LO +: PRI_W];
  assign b_pri = best_rec_r[PRI_LO +: PRI_W];

  // arrived and still has service left; strict > keeps the lowest index on ties
  assign e_ready = cmp_v_r && (e_arr <= t) && (e_rem != '0);
  assign take    = e_ready && (!found_r || (e_pri > b_pri));
  assign done    = busy_r && (scan_r == cnt) && !cmp_v_r;

  always_comb begin
    busy_nxt     = busy_r;
    scan_nxt     = scan_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_rec_nxt = best_rec_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      scan_nxt  = '0;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      if (scan_r < cnt) begin
        scan_nxt    = scan_r + CNT_W'(1);
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = AW'(scan_r);
      end
      if (take) begin
        found_nxt    = 1'b1;
        best_idx_nxt = cmp_idx_r;
        best_rec_nxt = rdata;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      cmp_v_r <= cmp_v_nxt;
      found_r <= found_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_rec_r <= best_rec_nxt;
  end

  assign raddr     = AW'(scan_r);
  assign sts.done  = done;
  assign sts.found = found_r;
  assign best_idx  = best_idx_r;
  assign best_rec  = best_rec_r;

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Process table in RAM, one-entry-per-cycle priority scan, per-tick service.
// ----------------------------------------------------------------------------
// A load request writes one process entry (arrival, burst, priority) into the
// table RAM; loading entry 0 also restarts time and the completion count. A
// tick request serves, for one tick, the arrived unfinished entry of highest
// priority among the first process_count entries (lowest index on a tie) and
// returns one result: the entry served, or idle, plus completion, turnaround,
// waiting and response times when the entry finishes. Every request gives
// exactly one result. A load goes straight to the hand-off; a tick walks the
// first process_count entries (capped at the table size) through the table
// RAM's single read port, one entry per cycle, then writes back the served
// entry, works out the metrics and hands the result off. Requests are handled
// one at a time, but a new request is taken while the previous result still
// waits in the output register. The process_count register may be written
// only while the block is idle. There is no clearing pass: entries never
// loaded read as garbage.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pps_in_if.sink     in_ch,
  pps_out_if.source  out_ch,
  pps_cfg_if.sink    cfg_ch
);
  import pps_pkg::*;

  localparam int AW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int TW     = TIME_BITS;
  localparam int RW     = 4 * TW + PRI_W;
  // table record layout, low to high: first_run, priority, remaining,
  // burst, arrival
  localparam int PRI_LO = TW;
  localparam int REM_LO = TW + PRI_W;
  localparam int BUR_LO = 2 * TW + PRI_W;
  localparam int ARR_LO = 3 * TW + PRI_W;
  localparam logic [TW-1:0] TMAX = '1;

  // control and bookkeeping
  state_t           state_r, state_nxt;
  logic [TW-1:0]    time_r,  time_nxt;
  logic [CNT_W-1:0] comp_r,  comp_nxt;
  logic [CNT_W-1:0] pcount_r, pcount_nxt;
  logic [CNT_W-1:0] cnt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r,  out_data_nxt;

  // result under construction and metric operands
  out_item_t        res_r, res_nxt;
  logic             fin_r, fin_nxt;
  logic [TW-1:0]    ct_r,  ct_nxt;
  logic [TW-1:0]    arr_r, arr_nxt;
  logic [TW-1:0]    fr_r,  fr_nxt;
  logic [TW:0]      ab_r,  ab_nxt;

  // table RAM
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [RW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [RW-1:0]    ram_rdata;

  // scan unit
  scan_ctl_t        scan_ctl;
  scan_sts_t        scan_sts;
  logic [AW-1:0]    best_idx;
  logic [RW-1:0]    best_rec;

  // served-entry fields and derived values
  logic [TW-1:0]    b_arr, b_bur, b_rem, b_fr;
  logic [PRI_W-1:0] b_pri;
  logic [TW-1:0]    rem_dec;
  logic [TW-1:0]    fr_upd;
  logic [TW-1:0]    ct_calc;
  logic [TW-1:0]    tat;
  logic [TW:0]      wait_full;
  logic [TW-1:0]    resp;

  logic             in_acc;
  logic             cfg_acc;
  logic             load_ok;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  assign pcount_nxt = cfg_acc ? cfg_ch.data : pcount_r;

  // counts above the table size clamp to the table size
  assign cnt = (int'(pcount_r) > MAX_PROCS) ? CNT_W'(MAX_PROCS) : pcount_r;

  // loads beyond the table are dropped but still answered
  assign load_ok = (int'(in_ch.data.entry_index) < MAX_PROCS);

  pps_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The scan only reads while no write is in flight (writes happen on the
  // load accept and in the update state), so no forwarding is needed.
  pps_scan #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .t        (time_r),
    .cnt      (cnt),
    .rdata    (ram_rdata),
    .raddr    (ram_raddr),
    .sts      (scan_sts),
    .best_idx (best_idx),
    .best_rec (best_rec)
  );

  assign b_arr = best_rec[ARR_LO +: TW];
  assign b_bur = best_rec[BUR_LO +: TW];
  assign b_rem = best_rec[REM_LO +: TW];
  assign b_pri = best_rec[PRI_LO +: PRI_W];
  assign b_fr  = best_rec[0 +: TW];

  assign rem_dec = b_rem - TW'(1);
  // first service happens while nothing has been consumed yet
  assign fr_upd  = (b_rem == b_bur) ? time_r : b_fr;
  assign ct_calc = (time_r == TMAX) ? time_r : time_r + TW'(1);

  // floored differences; waiting = ct - (arrival + burst), floored at zero
  assign tat       = (ct_r >= arr_r) ? ct_r - arr_r : '0;
  assign wait_full = ({1'b0, ct_r} >= ab_r) ? {1'b0, ct_r} - ab_r : '0;
  assign resp      = (fr_r >= arr_r) ? fr_r - arr_r : '0;

  always_comb begin
    state_nxt      = state_r;
    time_nxt       = time_r;
    comp_nxt       = comp_r;
    res_nxt        = res_r;
    fin_nxt        = fin_r;
    ct_nxt         = ct_r;
    arr_nxt        = arr_r;
    fr_nxt         = fr_r;
    ab_nxt         = ab_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(in_ch.data.entry_index);
    ram_wdata      = '0;
    scan_ctl.start = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.func == FUNC_LOAD) begin
            if (load_ok) begin
              ram_we    = 1'b1;
              ram_wdata = {TW'(in_ch.data.arrival_time),
                           TW'(in_ch.data.burst_time),
                           TW'(in_ch.data.burst_time),
                           in_ch.data.priority_level,
                           {TW{1'b0}}};
              if (in_ch.data.entry_index == '0) begin
                time_nxt = '0;
                comp_nxt = '0;
              end
            end
            res_nxt           = '0;
            res_nxt.idle      = 1'b1;
            res_nxt.all_done  = (comp_nxt == cnt);
            res_nxt.tick_time = FLD_W'(time_nxt);
            state_nxt         = S_EMIT;
          end else begin
            scan_ctl.start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_sts.done) begin
          state_nxt = S_UPDATE;
        end
      end

      // write back the served entry when one was found, advance time
      S_UPDATE: begin
        res_nxt = '0;
        fin_nxt = 1'b0;
        if (scan_sts.found) begin
          ram_we    = 1'b1;
          ram_waddr = best_idx;
          ram_wdata = {b_arr, b_bur, rem_dec, b_pri, fr_upd};
          res_nxt.running_index = IDX_W'(best_idx);
          fin_nxt = (rem_dec == '0);
          ct_nxt  = ct_calc;
          arr_nxt = b_arr;
          fr_nxt  = fr_upd;
          ab_nxt  = {1'b0, b_arr} + {1'b0, b_bur};
          if ((rem_dec == '0) && (comp_r != CNT_MAX)) begin
            comp_nxt = comp_r + CNT_W'(1);
          end
        end else begin
          res_nxt.idle = 1'b1;
        end
        res_nxt.all_done  = (comp_nxt == cnt);
        res_nxt.tick_time = FLD_W'(time_r);
        time_nxt          = ct_calc;
        state_nxt         = S_METRIC;
      end

      S_METRIC: begin
        if (fin_r) begin
          res_nxt.finished        = 1'b1;
          res_nxt.completion_time = FLD_W'(ct_r);
          res_nxt.turnaround      = FLD_W'(tat);
          res_nxt.waiting         = FLD_W'(wait_full);
          res_nxt.response        = FLD_W'(resp);
        end
        state_nxt = S_EMIT;
      end

      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      comp_r      <= '0;
      pcount_r    <= CNT_W'(1);
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      comp_r      <= comp_nxt;
      pcount_r    <= pcount_nxt;
      out_valid_r <= out_valid_nxt;
      fin_r       <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    ct_r       <= ct_nxt;
    arr_r      <= arr_nxt;
    fr_r       <= fr_nxt;
    ab_r       <= ab_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

### sim/tb_preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler
// Self-checking bench for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
// A queue of pending jobs (load and tick requests, process_count writes) is
// filled at time zero. A clocked driver presents them in bursts with random
// gaps. A clocked monitor keeps a request-level copy of the process table,
// works out the result of every accepted request and checks each returned
// result field by field, in order. The result side stalls on a rotating
// pattern of its own. Phases: short directed cases, random runs, and a churn
// of completions, run back to back with the result side always ready, that
// saturates the completion counter.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;
  import pps_pkg::*;

  localparam int          NPROC     = MAX_PROCS_DEF;
  localparam logic [15:0] TIME_TOP  = 16'hFFFF;
  localparam int          RAND_REQS = 1350;
  localparam int unsigned LIMIT     = 4_000_000;

  typedef enum logic [0:0] {
    JOB_REQUEST,
    JOB_SET_COUNT
  } job_kind_t;

  typedef struct {
    job_kind_t        kind;
    in_item_t         rq;
    logic [CNT_W-1:0] count;
    bit               flat;   // no gaps and no stalls while this runs
  } job_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();
  pps_cfg_if cfg_ch ();

  preemptive_priority_scheduler u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  job_t        job_q[$];
  out_item_t   pending_outcomes[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // handshake flags, set at the rising edge, consumed at the falling edge
  bit rq_taken  = 1'b0;
  bit cfg_taken = 1'b0;
  bit flat_mode = 1'b0;
  bit gen_flat  = 1'b0;

  // sender burst / gap counters
  int unsigned send_left = 1;
  int unsigned hold_off  = 0;

  // receiver stall pattern
  logic [31:0] stall_pat  = '1;
  int unsigned stall_left = 0;

  // shadow copy of the scheduler
  logic [15:0]      arr_tbl [NPROC];
  logic [15:0]      bst_tbl [NPROC];
  logic [15:0]      rem_tbl [NPROC];
  logic [15:0]      frt_tbl [NPROC];
  logic [PRI_W-1:0] pri_tbl [NPROC];
  logic [15:0]      now_t    = '0;
  logic [CNT_W-1:0] done_cnt = '0;
  logic [CNT_W-1:0] proc_cnt = 7'd1;

  function automatic logic [15:0] floor_diff(logic [15:0] a, logic [15:0] b);
    return (a >= b) ? a - b : 16'd0;
  endfunction

  // One request in, one result out, shadow state updated on the way.
  function automatic out_item_t predict_schedule(in_item_t rq);
    out_item_t        res;
    logic [CNT_W-1:0] span;
    logic             found;
    logic [IDX_W-1:0] best;
    logic [PRI_W-1:0] best_pri;
    logic [15:0]      t;
    logic [15:0]      ct;
    logic [15:0]      tat;
    int               i;
    res  = '0;
    span = (proc_cnt > NPROC) ? CNT_W'(NPROC) : proc_cnt;

    if (rq.func == FUNC_LOAD) begin
      arr_tbl[rq.entry_index] = rq.arrival_time;
      bst_tbl[rq.entry_index] = rq.burst_time;
      rem_tbl[rq.entry_index] = rq.burst_time;
      pri_tbl[rq.entry_index] = rq.priority_level;
      frt_tbl[rq.entry_index] = '0;
      // entry 0 restarts the schedule
      if (rq.entry_index == 0) begin
        now_t    = '0;
        done_cnt = '0;
      end
      res.idle      = 1'b1;
      res.all_done  = (done_cnt == span);
      res.tick_time = now_t;
      return res;
    end

    // tick: highest priority among arrived, unfinished entries; first wins ties
    t        = now_t;
    found    = 1'b0;
    best     = '0;
    best_pri = '0;
    for (i = 0; i < span; i++) begin
      if (arr_tbl[i] <= t && rem_tbl[i] != 0) begin
        if (!found || pri_tbl[i] > best_pri) begin
          found    = 1'b1;
          best_pri = pri_tbl[i];
          best     = IDX_W'(i);
        end
      end
    end

    if (found) begin
      res.running_index = best;
      if (rem_tbl[best] == bst_tbl[best])
        frt_tbl[best] = t;
      rem_tbl[best] = rem_tbl[best] - 16'd1;
      if (rem_tbl[best] == 0) begin
        ct  = (t != TIME_TOP) ? t + 16'd1 : TIME_TOP;
        tat = floor_diff(ct, arr_tbl[best]);
        if (done_cnt != CNT_MAX)
          done_cnt = done_cnt + 1'b1;
        res.finished        = 1'b1;
        res.completion_time = ct;
        res.turnaround      = tat;
        res.waiting         = floor_diff(tat, bst_tbl[best]);
        res.response        = floor_diff(frt_tbl[best], arr_tbl[best]);
      end
    end else begin
      res.idle = 1'b1;
    end

    res.all_done  = (done_cnt == span);
    res.tick_time = t;
    if (now_t != TIME_TOP)
      now_t = now_t + 16'd1;
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Job queue helpers
  // --------------------------------------------------------------------------
  task automatic queue_load(int idx, int arr, int bst, int pri);
    job_t j;
    j.kind                 = JOB_REQUEST;
    j.rq.func              = FUNC_LOAD;
    j.rq.entry_index       = IDX_W'(idx);
    j.rq.arrival_time      = 16'(arr);
    j.rq.burst_time        = 16'(bst);
    j.rq.priority_level    = PRI_W'(pri);
    j.count                = '0;
    j.flat                 = gen_flat;
    job_q.push_back(j);
  endtask

  task automatic queue_ticks(int n);
    job_t j;
    j.kind              = JOB_REQUEST;
    j.rq                = '0;
    j.rq.func           = FUNC_TICK;
    // payload on a tick is don't-care; give it random bits
    j.rq.entry_index    = IDX_W'($urandom);
    j.rq.arrival_time   = 16'($urandom);
    j.count             = '0;
    j.flat              = gen_flat;
    repeat (n) job_q.push_back(j);
  endtask

  task automatic queue_count(int n);
    job_t j;
    j.kind  = JOB_SET_COUNT;
    j.rq    = '0;
    j.count = CNT_W'(n);
    j.flat  = gen_flat;
    job_q.push_back(j);
  endtask

  // Mostly short bursts arriving within the run; now and then a full-range
  // field, a zero burst or a very long one.
  task automatic queue_random_load(int idx, int horizon, bit tight_pri);
    int arr;
    int bst;
    int pri;
    arr = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, horizon);
    case ($urandom_range(0, 19))
      0:       bst = 0;
      1:       bst = $urandom_range(1, 65535);
      2:       bst = 65535;
      default: bst = $urandom_range(1, 6);
    endcase
    pri = tight_pri ? $urandom_range(0, 3) : $urandom_range(0, 255);
    queue_load(idx, arr, bst, pri);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    int rand_reqs;
    int run_no;
    int pcnt;
    int span;
    int horizon;
    int n_ticks;
    int k;
    bit tight;

    // directed: reset count of 1, one entry served to completion, then idle
    queue_load(0, 0, 2, 255);
    queue_ticks(3);
    // preemption by a late high-priority arrival, a burst of zero, and a
    // full-range load outside the scanned span
    queue_count(3);
    queue_load(0, 0, 3, 0);
    queue_load(1, 1, 1, 255);
    queue_load(2, 1, 0, 200);
    queue_load(63, 65535, 65535, 255);
    queue_ticks(5);
    // equal priorities: lowest index first
    queue_count(2);
    queue_load(0, 0, 1, 7);
    queue_load(1, 0, 1, 7);
    queue_ticks(2);
    // empty span: nothing scanned, all_done holds
    queue_count(0);
    queue_load(0, 1, 1, 1);
    queue_ticks(2);

    // random runs: count written while idle, span loaded, then ticks with
    // the odd stray or mid-run load thrown in
    rand_reqs = 0;
    run_no    = 0;
    while (rand_reqs < RAND_REQS) begin
      case (run_no)
        0:       pcnt = 127;
        1:       pcnt = NPROC;
        default: begin
          case ($urandom_range(0, 9))
            0:       pcnt = 0;
            1:       pcnt = $urandom_range(NPROC + 1, 127);
            2:       pcnt = NPROC;
            default: pcnt = $urandom_range(1, 16);
          endcase
        end
      endcase
      span    = (pcnt > NPROC) ? NPROC : pcnt;
      horizon = $urandom_range(4, 40);
      tight   = 1'($urandom_range(0, 1));
      queue_count(pcnt);
      queue_random_load(0, horizon, tight);
      for (k = 1; k < span; k++)
        queue_random_load(k, horizon, tight);
      n_ticks    = horizon + $urandom_range(0, 20);
      rand_reqs += (span > 0 ? span : 1) + n_ticks;
      for (k = 0; k < n_ticks; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_random_load($urandom_range(0, NPROC - 1), horizon, tight);
          rand_reqs++;
        end
        queue_ticks(1);
      end
      run_no++;
    end

    // completion churn, run flat out: reload entry 1 over and over so the
    // completed count runs into its ceiling
    gen_flat = 1'b1;
    queue_count(2);
    queue_load(0, 0, 1, 0);
    queue_load(1, 0, 1, 9);
    queue_ticks(2);
    repeat (130) begin
      queue_load(1, 0, 1, 9);
      queue_ticks(1);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (job_q.size() != 0 || in_ch.valid || cfg_ch.valid ||
           pending_outcomes.size() != 0)
      @(posedge clk);
    // let any stray result surface
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog_proc
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: one nonblocking update per signal per falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : feed_proc
    logic             v_nx;
    logic             cv_nx;
    in_item_t         d_nx;
    logic [CNT_W-1:0] cd_nx;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.data   <= '0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.data  <= '0;
    end else begin
      v_nx      = in_ch.valid & ~rq_taken;
      cv_nx     = cfg_ch.valid & ~cfg_taken;
      d_nx      = in_ch.data;
      cd_nx     = cfg_ch.data;
      rq_taken  = 1'b0;
      cfg_taken = 1'b0;
      if (!v_nx && !cv_nx && job_q.size() != 0) begin
        if (job_q[0].kind == JOB_SET_COUNT) begin
          // count changes only once every result is home
          if (pending_outcomes.size() == 0) begin
            cv_nx = 1'b1;
            cd_nx = job_q[0].count;
            void'(job_q.pop_front());
          end
        end else if (hold_off != 0) begin
          hold_off--;
        end else begin
          v_nx      = 1'b1;
          d_nx      = job_q[0].rq;
          flat_mode = job_q[0].flat;
          void'(job_q.pop_front());
          if (send_left > 1) begin
            send_left--;
          end else begin
            send_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 12);
            case ($urandom_range(0, 7))
              0, 1:    hold_off = 0;
              2:       hold_off = $urandom_range(20, 90);
              default: hold_off = $urandom_range(1, 6);
            endcase
            if (flat_mode)
              hold_off = 0;
          end
        end
      end
      in_ch.valid  <= v_nx;
      in_ch.data   <= d_nx;
      cfg_ch.valid <= cv_nx;
      cfg_ch.data  <= cd_nx;
    end
  end

  // Result side back-pressure: a rotating 32-bit pattern, swapped every so
  // often; some patterns are solid ready, some mostly stalled.
  always @(negedge clk) begin : stall_proc
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (flat_mode) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = $urandom & $urandom;
          default: stall_pat = $urandom;
        endcase
        if (stall_pat == 0)
          stall_pat = 32'h1;
        stall_left = $urandom_range(16, 200);
      end
      out_ch.ready <= stall_pat[0];
      stall_pat     = {stall_pat[0], stall_pat[31:1]};
      stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: results checked before this edge's request is predicted, so a
  // result never meets its own request's expectation early
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with no request outstanding: running_index=%0d tick_time=%0d",
                 out_ch.data.running_index, out_ch.data.tick_time);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("idle", 16'(want.idle), 16'(out_ch.data.idle));
          check_field("running_index", 16'(want.running_index),
                      16'(out_ch.data.running_index));
          check_field("finished", 16'(want.finished), 16'(out_ch.data.finished));
          check_field("completion_time", want.completion_time,
                      out_ch.data.completion_time);
          check_field("turnaround",      want.turnaround,      out_ch.data.turnaround);
          check_field("waiting",         want.waiting,         out_ch.data.waiting);
          check_field("response",        want.response,        out_ch.data.response);
          check_field("all_done", 16'(want.all_done), 16'(out_ch.data.all_done));
          check_field("tick_time",       want.tick_time,       out_ch.data.tick_time);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        proc_cnt  = cfg_ch.data;
        cfg_taken = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_outcomes.push_back(predict_schedule(in_ch.data));
        rq_taken = 1'b1;
      end
    end
  end

endmodule
